### rtl/mcba_pkg.sv
`timescale 1ns / 1ps
// mcba_pkg: sizes, constants and beat types of the multichannel boxcar averager
// no dependencies; used by the top level, the window ram instance and the checker

package mcba_pkg;

    localparam int WINDOW_LEN   = 200;
    localparam int NUM_CHANNELS = 5;
    localparam int SAMPLE_BITS  = 12;

    // fixed field widths
    localparam int CHAN_BITS   = 3;
    localparam int COUNT_BITS  = 8;
    localparam int THRESH_BITS = 8;

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = '1;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(100);

    // derived sizes
    localparam int CH_IDX_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int POS_BITS    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int MEM_DEPTH   = NUM_CHANNELS * WINDOW_LEN;
    localparam int ADDR_BITS   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // sum / WINDOW_LEN as a multiply by a rounded-up reciprocal, exact for every sum
    localparam int DIV_SHIFT  = SUM_BITS + $clog2(WINDOW_LEN);
    localparam int RECIP_BITS = SUM_BITS + 1;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] DIV_RECIP =
        RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    typedef struct packed {
        logic [CHAN_BITS-1:0]   channel;
        logic [SAMPLE_BITS-1:0] sample;
    } t_in_beat;

    typedef struct packed {
        logic [CHAN_BITS-1:0]   out_channel;
        logic [SAMPLE_BITS-1:0] average;
        logic                   warmed_up;
    } t_out_beat;

endpackage

### rtl/multichannel_boxcar_averager.sv
`timescale 1ns / 1ps
// multichannel_boxcar_averager: per-channel 200-sample moving average of adc samples
// depends on mcba_pkg and mcba_ram

// usage
//   input channel: i_valid / o_stall carry an adc sample tagged with its channel
//   number; a beat is taken when i_valid is high and o_stall is low. channel numbers
//   of 5 and above are taken and dropped without any result or state change.
//   output channel: o_valid / i_stall carry the channel, its window average and the
//   warmed-up flag; one output beat per valid input beat, in input order.
//   configuration: i_cfg_wr_en writes i_cfg_wr_data into the warm-up threshold.
// throughput and pipeline
//   one beat per cycle sustained while i_stall stays low; a taken beat goes through the
//   window ram read, running-sum update and reciprocal multiply registers to o_valid.
//   the window ram read and write back of one channel never hit the same entry in
//   flight, since the write position steps on at the moment a beat is taken.
// reset
//   synchronous, active low; empties the pipeline, clears positions, sums, counts and
//   the flag, and loads the threshold with 100. the window ram is not swept: an entry
//   counts as zero until its channel has wrapped once, so beats are taken right away.
// back-pressure
//   a stalled result holds on o_data; upstream stages keep filling bubbles, and
//   o_stall rises only once all three stages hold a beat.

module multichannel_boxcar_averager (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  mcba_pkg::t_in_beat                  i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output mcba_pkg::t_out_beat                 o_data,
    input  logic                                i_cfg_wr_en,
    input  logic [mcba_pkg::THRESH_BITS-1:0]    i_cfg_wr_data
);

    // control state: per-channel positions, wrap bits, sums and counts; shared threshold and flag
    logic [mcba_pkg::THRESH_BITS-1:0] r_thresh;
    logic [mcba_pkg::POS_BITS-1:0]    r_pos     [mcba_pkg::NUM_CHANNELS];
    logic [mcba_pkg::NUM_CHANNELS-1:0] r_wrapped;
    logic [mcba_pkg::SUM_BITS-1:0]    r_sum     [mcba_pkg::NUM_CHANNELS];
    logic [mcba_pkg::COUNT_BITS-1:0]  r_count   [mcba_pkg::NUM_CHANNELS];
    logic [mcba_pkg::COUNT_BITS-1:0]  n_count   [mcba_pkg::NUM_CHANNELS];
    logic                             r_flag;
    logic                             n_flag;

    // stage 1: waiting on the window ram read
    logic                             r1_valid;
    logic [mcba_pkg::CH_IDX_BITS-1:0] r1_chan;
    logic [mcba_pkg::SAMPLE_BITS-1:0] r1_sample;
    logic [mcba_pkg::ADDR_BITS-1:0]   r1_addr;
    logic                             r1_old_ok;
    logic                             r1_flag;

    // stage 2: updated sum, ready for the divide
    logic                             r2_valid;
    logic [mcba_pkg::CH_IDX_BITS-1:0] r2_chan;
    logic [mcba_pkg::SUM_BITS-1:0]    r2_sum;
    logic                             r2_flag;

    // output register
    logic                             r_ovalid;
    mcba_pkg::t_out_beat              r_odata;

    logic                             en0, en1, en2;
    logic                             in_ok;
    logic                             s0_regular_warm;
    logic [mcba_pkg::CH_IDX_BITS-1:0] s0_ch;
    logic [mcba_pkg::POS_BITS-1:0]    s0_pos;
    logic [mcba_pkg::ADDR_BITS-1:0]   s0_addr;
    logic                             s0_pos_last;
    logic [mcba_pkg::SAMPLE_BITS-1:0] ram_rd_data;
    logic [mcba_pkg::SAMPLE_BITS-1:0] s1_old;
    logic [mcba_pkg::SUM_BITS-1:0]    s1_sum;
    logic                             s1_move;
    logic [mcba_pkg::PROD_BITS-1:0]   s2_prod;

    // each stage moves when the one after it is empty or moving
    assign en2     = !r_ovalid || !i_stall;
    assign en1     = !r2_valid || en2;
    assign en0     = !r1_valid || en1;
    assign o_stall = !en0;

    assign in_ok = i_valid && en0 && (int'(i_data.channel) < mcba_pkg::NUM_CHANNELS);

    // stage 0: locate the oldest entry and advance the write position
    assign s0_ch       = mcba_pkg::CH_IDX_BITS'(i_data.channel);
    assign s0_pos      = r_pos[s0_ch];
    assign s0_pos_last = (s0_pos == mcba_pkg::POS_BITS'(mcba_pkg::WINDOW_LEN - 1));
    assign s0_addr     = mcba_pkg::ADDR_BITS'(int'(s0_ch) * mcba_pkg::WINDOW_LEN
                                              + int'(s0_pos));

    always_comb begin
        s0_regular_warm = 1'b1;
        for (int i = 0; i < mcba_pkg::NUM_CHANNELS; i++) begin
            n_count[i] = r_count[i];
            if (in_ok && (int'(s0_ch) == i) && (r_count[i] != mcba_pkg::COUNT_MAX)) begin
                n_count[i] = r_count[i] + 1'b1;
            end
        end
        // channels 0..2 gate the flag; a missing regular channel never passes
        for (int i = 0; i < 3; i++) begin
            if (i < mcba_pkg::NUM_CHANNELS) begin
                if (!(n_count[i] > r_thresh)) begin
                    s0_regular_warm = 1'b0;
                end
            end else begin
                s0_regular_warm = 1'b0;
            end
        end
        // flag is sticky and only moves on a taken sample
        n_flag = r_flag || (in_ok && s0_regular_warm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= mcba_pkg::THRESH_RESET;
            r_wrapped <= '0;
            r_flag    <= 1'b0;
            for (int i = 0; i < mcba_pkg::NUM_CHANNELS; i++) begin
                r_pos[i]   <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_thresh <= i_cfg_wr_data;
            end
            r_flag <= n_flag;
            for (int i = 0; i < mcba_pkg::NUM_CHANNELS; i++) begin
                r_count[i] <= n_count[i];
            end
            if (in_ok) begin
                if (s0_pos_last) begin
                    r_pos[s0_ch]     <= '0;
                    r_wrapped[s0_ch] <= 1'b1;
                end else begin
                    r_pos[s0_ch] <= s0_pos + 1'b1;
                end
            end
        end
    end

    // window store; stage 1 counts an entry of a channel that has not wrapped yet as zero
    mcba_ram #(
        .WIDTH (mcba_pkg::SAMPLE_BITS),
        .DEPTH (mcba_pkg::MEM_DEPTH)
    ) u_window_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_move),
        .i_wr_addr (r1_addr),
        .i_wr_data (r1_sample),
        .i_rd_en   (in_ok),
        .i_rd_addr (s0_addr),
        .o_rd_data (ram_rd_data)
    );

    // stage 1: running sum update and write back of the new sample
    assign s1_move = r1_valid && en1;
    assign s1_old  = r1_old_ok ? ram_rd_data : '0;
    assign s1_sum  = r_sum[r1_chan] - mcba_pkg::SUM_BITS'(s1_old)
                                    + mcba_pkg::SUM_BITS'(r1_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            for (int i = 0; i < mcba_pkg::NUM_CHANNELS; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (en0) begin
                r1_valid <= in_ok;
            end
            if (s1_move) begin
                r_sum[r1_chan] <= s1_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r1_chan   <= s0_ch;
            r1_sample <= i_data.sample;
            r1_addr   <= s0_addr;
            r1_old_ok <= r_wrapped[s0_ch];
            r1_flag   <= n_flag;
        end
    end

    // stage 2: divide by the window length through the reciprocal
    assign s2_prod = mcba_pkg::PROD_BITS'(r2_sum) * mcba_pkg::PROD_BITS'(mcba_pkg::DIV_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (en1) begin
                r2_valid <= r1_valid;
            end
            if (en2) begin
                r_ovalid <= r2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r2_chan <= r1_chan;
            r2_sum  <= s1_sum;
            r2_flag <= r1_flag;
        end
        if (en2) begin
            r_odata.out_channel <= mcba_pkg::CHAN_BITS'(r2_chan);
            r_odata.average     <= s2_prod[mcba_pkg::DIV_SHIFT +: mcba_pkg::SAMPLE_BITS];
            r_odata.warmed_up   <= r2_flag;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

### rtl/mcba_ram.sv
`timescale 1ns / 1ps
// mcba_ram: generic simple dual port ram, one write port, one registered read port
// no dependencies

module mcba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/mcba_checker.sv
`timescale 1ns / 1ps
// mcba_checker: port-level checks of the multichannel boxcar averager, bound to the top
// depends on mcba_pkg

module mcba_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             o_stall,
    input  mcba_pkg::t_in_beat               i_data,
    input  logic                             o_valid,
    input  logic                             i_stall,
    input  mcba_pkg::t_out_beat              o_data
);

    logic       in_fire;
    logic       out_fire;
    logic [2:0] r_pending;
    logic       r_seen_warm;

    // beats in flight: valid-channel inputs taken minus outputs taken
    assign in_fire  = i_valid && !o_stall
                      && (int'(i_data.channel) < mcba_pkg::NUM_CHANNELS);
    assign out_fire = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_seen_warm <= 1'b0;
        end else begin
            r_pending <= r_pending + 3'(in_fire) - 3'(out_fire);
            if (out_fire && o_data.warmed_up) begin
                r_seen_warm <= 1'b1;
            end
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    // no result without a matching taken sample, and no more than the pipeline holds
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid |-> r_pending != 3'd0) && (r_pending <= 3'd3))
        else $error("output beat count does not match taken input beats");

    // warmed-up flag never drops once reported
    a_warm_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_seen_warm |-> o_data.warmed_up)
        else $error("warmed-up flag fell");

    // an empty output register never holds off the input
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> int'(o_data.out_channel) < mcba_pkg::NUM_CHANNELS)
        else $error("output channel out of range");

endmodule

bind multichannel_boxcar_averager mcba_checker u_mcba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_data        (i_data),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_data        (o_data)
);
